// ===== hw/rtl/buzzer_pin_audio_sampler_top_assert.svh =====
// assertion macros for the buzzer pin audio sampler checker
// expects clk and rst in the scope of use
`ifndef BUZZER_PIN_AUDIO_SAMPLER_TOP_ASSERT_SVH
`define BUZZER_PIN_AUDIO_SAMPLER_TOP_ASSERT_SVH

// same-cycle implication
`define BPAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BPAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// implication that also holds across reset
`define BPAS_ASSERT_RAW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bpas_pkg.sv =====
// types and constants of the buzzer pin audio sampler
// no dependencies
package bpas_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_END   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_ACTIVE  = 2'd0,
    MODE_PASSIVE = 2'd1,
    MODE_TONE    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE        = 3'd0,
    REG_ACTIVE_HIGH = 3'd1,
    REG_PIN_CONN    = 3'd2,
    REG_DECIMATION  = 3'd3,
    REG_SAMPLE_RATE = 3'd4,
    REG_AMPLITUDE   = 3'd5,
    REG_FRAME_LIMIT = 3'd6,
    REG_UNUSED      = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_STATUS = 2'd1,
    OP_TONE   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL0,
    BK_MUL1,
    BK_MUL2,
    BK_ACC,
    BK_RND,
    BK_DIV,
    BK_DEC
  } bk_state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        active_high;
    logic        pin_connected;
    logic [15:0] decimation;
    logic [16:0] sample_rate;
    logic [14:0] amplitude;
    logic [15:0] frame_limit;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic        drive;
    logic        beep;
    logic [31:0] period;
  } entry_t;

  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 3;

  localparam logic [7:0]  ACT_HIGH_LIMIT = 8'd65;
  localparam logic [9:0]  ACT_LOW_BASE   = 10'd310;
  localparam logic [9:0]  ACT_LOW_LIMIT  = 10'd215;
  localparam logic [24:0] MIN_TONE_HZ    = 25'd100;
  localparam logic [24:0] TONE_STEP_HZ   = 25'd10;
  localparam logic [31:0] MIN_PERIOD_Q8  = 32'd1280;
  localparam logic [23:0] EDGE_MAX       = 24'hFFFFFF;
  localparam int          DIV_STEPS      = 25;

endpackage

// ===== hw/rtl/bpas_if.sv =====
// channel interfaces of the buzzer pin audio sampler
// depends on bpas_pkg
interface bpas_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       pin_level;
  logic [7:0] pin_average;
  modport source (output valid, command, pin_level, pin_average, input ready);
  modport sink (input valid, command, pin_level, pin_average, output ready);
endinterface

interface bpas_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] sample;
  logic               beep_on;
  logic               tone_restart;
  logic [16:0]        tone_freq;
  modport source (output valid, kind, sample, beep_on, tone_restart, tone_freq, input ready);
  modport sink (input valid, kind, sample, beep_on, tone_restart, tone_freq, output ready);
endinterface

interface bpas_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bpas_pkg::CFG_IDX_W-1:0]  index;
  logic [bpas_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/bpas_fifo.sv =====
// short request queue between front and back
// depends on bpas_pkg
module bpas_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bpas_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output bpas_pkg::entry_t pop_data,
  output logic             not_empty
);
  import bpas_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ===== hw/rtl/bpas_front.sv =====
// front end: accepts items, paces ticks, tracks frame and edge state, queues work
// depends on bpas_pkg, bpas_if
module bpas_front (
  input  logic             clk,
  input  logic             rst,
  input  bpas_pkg::cfg_t   cfg,
  bpas_in_if.sink          in_ch,
  input  logic             q_full,
  output logic             push,
  output bpas_pkg::entry_t push_data
);
  import bpas_pkg::*;

  logic [15:0] tick_count;
  logic [15:0] frame_count;
  logic [23:0] edge_count;
  logic [31:0] period_avg;
  logic        last_level;

  logic        acc;
  logic        fire;
  logic        drive;
  logic        beep_act;
  logic [32:0] avg_sum;

  assign in_ch.ready = !q_full;
  assign acc   = in_ch.valid && in_ch.ready;
  assign fire  = (tick_count >= cfg.decimation);
  assign drive = cfg.active_high ? in_ch.pin_level : !in_ch.pin_level;
  assign avg_sum = {1'b0, period_avg} + {1'b0, edge_count, 8'd0};
  assign beep_act = cfg.pin_connected && (cfg.active_high ?
                    (in_ch.pin_average > ACT_HIGH_LIMIT) :
                    ((ACT_LOW_BASE - {2'd0, in_ch.pin_average}) > ACT_LOW_LIMIT));

  always_comb begin
    push      = 1'b0;
    push_data = '{op: OP_STATUS, drive: drive, beep: 1'b0, period: period_avg};
    if (acc) begin
      unique case (cmd_t'(in_ch.command))
        CMD_TICK: begin
          if (mode_t'(cfg.mode) == MODE_PASSIVE && fire && cfg.pin_connected &&
              frame_count < cfg.frame_limit) begin
            push         = 1'b1;
            push_data.op = OP_SAMPLE;
          end
        end
        CMD_END: begin
          push = 1'b1;
          unique case (mode_t'(cfg.mode))
            MODE_ACTIVE: push_data.beep = beep_act;
            MODE_TONE:   push_data.op = OP_TONE;
            default:     push_data.beep = 1'b0;
          endcase
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      frame_count <= '0;
      edge_count  <= '0;
      period_avg  <= '0;
      last_level  <= 1'b0;
    end else if (acc) begin
      unique case (cmd_t'(in_ch.command))
        CMD_TICK: begin
          if (mode_t'(cfg.mode) == MODE_PASSIVE || mode_t'(cfg.mode) == MODE_TONE) begin
            tick_count <= fire ? '0 : tick_count + 1'b1;
          end
          if (push) begin
            frame_count <= frame_count + 1'b1;
          end
          if (mode_t'(cfg.mode) == MODE_TONE && fire && cfg.pin_connected) begin
            last_level <= in_ch.pin_level;
            if (!last_level && in_ch.pin_level) begin
              period_avg <= avg_sum[32:1];
              edge_count <= 24'd1;
            end else if (edge_count < EDGE_MAX) begin
              edge_count <= edge_count + 1'b1;
            end
          end
        end
        CMD_START: begin
          if (mode_t'(cfg.mode) == MODE_PASSIVE) begin
            tick_count <= cfg.decimation;
          end else if (mode_t'(cfg.mode) == MODE_TONE) begin
            tick_count <= cfg.decimation;
            edge_count <= '0;
            last_level <= 1'b0;
            period_avg <= '0;
          end
        end
        CMD_END: begin
          if (mode_t'(cfg.mode) == MODE_PASSIVE) begin
            frame_count <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end
endmodule

// ===== hw/rtl/bpas_back.sv =====
// back end: iir filter on a shared multiplier, tone frequency divider, result register
// depends on bpas_pkg, bpas_if
module bpas_back #(
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  bpas_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  bpas_pkg::entry_t q_data,
  output logic             pop,
  bpas_out_if.source       out_ch
);
  import bpas_pkg::*;

  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int PW = CW + 33;
  localparam int AW = PW + 2;
  localparam longint CfNumL = (64'sd7837 * (64'sd1 <<< COEF_FRAC_BITS) + 64'sd5000) / 64'sd10000;
  localparam longint CfP1L  = (64'sd1196 * (64'sd1 <<< COEF_FRAC_BITS) + 64'sd500) / 64'sd1000;
  localparam longint CfP2L  = (64'sd2068 * (64'sd1 <<< COEF_FRAC_BITS) + 64'sd5000) / 64'sd10000;
  localparam logic signed [CW-1:0] CF_NUM = CW'(CfNumL);
  localparam logic signed [CW-1:0] CF_P1  = CW'(CfP1L);
  localparam logic signed [CW-1:0] CF_P2  = CW'(CfP2L);
  localparam logic signed [AW-1:0] RND_HALF = AW'(64'sd1 <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [AW-1:0] Y_MAX = AW'(64'sd2147483647);
  localparam logic signed [AW-1:0] Y_MIN = -AW'(64'sd2147483648);

  bk_state_t state, state_next;

  logic signed [16:0] x0, x1, x2;
  logic signed [31:0] y0, y1, y2;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc;
  logic [31:0] div_d;
  logic [31:0] rem;
  logic [24:0] num;
  logic [24:0] quo;
  logic [4:0]  step;
  logic [16:0] last_freq;

  logic signed [17:0] xdiff;
  logic signed [AW-1:0] y_full;
  logic signed [31:0] y_sat;
  logic signed [32:0] y_bias;
  logic signed [23:0] t_val;
  logic signed [15:0] t_sat;
  logic [32:0] rem_sh;
  logic        rem_ge;
  logic [24:0] fdiff;
  logic        f_ok;

  assign pop = (state == BK_IDLE) && q_valid && !out_ch.valid;
  assign xdiff = {x1[16], x1} - {x2[16], x2};
  assign y_full = (acc + RND_HALF) >>> COEF_FRAC_BITS;
  assign y_sat = (y_full > Y_MAX) ? 32'sh7FFFFFFF :
                 (y_full < Y_MIN) ? 32'sh80000000 : y_full[31:0];
  assign y_bias = y_sat[31] ? ({y_sat[31], y_sat} + 33'sd255) : {y_sat[31], y_sat};
  assign t_val = 24'(y_bias >>> 8);
  assign t_sat = (t_val > 24'sd32767) ? 16'sh7FFF :
                 (t_val < -24'sd32768) ? 16'sh8000 : t_val[15:0];
  assign rem_sh = {rem, num[24]};
  assign rem_ge = (rem_sh >= {1'b0, div_d});
  assign f_ok = (quo > MIN_TONE_HZ);
  assign fdiff = ({8'd0, last_freq} > quo) ? {8'd0, last_freq} - quo : quo - {8'd0, last_freq};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (pop) begin
          unique case (q_data.op)
            OP_SAMPLE: state_next = BK_MUL0;
            OP_TONE:   state_next = (q_data.period > MIN_PERIOD_Q8) ? BK_DIV : BK_DEC;
            default:   state_next = BK_IDLE;
          endcase
        end
      end
      BK_MUL0: state_next = BK_MUL1;
      BK_MUL1: state_next = BK_MUL2;
      BK_MUL2: state_next = BK_ACC;
      BK_ACC:  state_next = BK_RND;
      BK_RND:  state_next = BK_IDLE;
      BK_DIV:  state_next = (step == 5'(DIV_STEPS - 1)) ? BK_DEC : BK_DIV;
      BK_DEC:  state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x0 <= '0;
      x1 <= '0;
      x2 <= '0;
      y0 <= '0;
      y1 <= '0;
      y2 <= '0;
      last_freq <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        BK_IDLE: begin
          if (pop) begin
            div_d <= q_data.period;
            rem   <= '0;
            quo   <= '0;
            num   <= {cfg.sample_rate, 8'd0};
            step  <= '0;
            if (q_data.op == OP_SAMPLE) begin
              x2 <= x1;
              x1 <= x0;
              x0 <= q_data.drive ? $signed({2'b00, cfg.amplitude}) :
                                   -$signed({2'b00, cfg.amplitude});
              y2 <= y1;
              y1 <= y0;
            end else if (q_data.op != OP_TONE) begin
              out_ch.valid        <= 1'b1;
              out_ch.kind         <= 1'b1;
              out_ch.sample       <= '0;
              out_ch.beep_on      <= q_data.beep;
              out_ch.tone_restart <= 1'b0;
              out_ch.tone_freq    <= '0;
            end
          end
        end
        BK_MUL0: prod <= PW'(CF_NUM) * PW'(xdiff);
        BK_MUL1: begin
          acc  <= AW'(prod) <<< 7;
          prod <= PW'(CF_P1) * PW'(y1);
        end
        BK_MUL2: begin
          acc  <= acc + AW'(prod);
          prod <= PW'(CF_P2) * PW'(y2);
        end
        BK_ACC: acc <= acc - AW'(prod);
        BK_RND: begin
          y0                  <= y_sat;
          out_ch.valid        <= 1'b1;
          out_ch.kind         <= 1'b0;
          out_ch.sample       <= t_sat;
          out_ch.beep_on      <= 1'b0;
          out_ch.tone_restart <= 1'b0;
          out_ch.tone_freq    <= '0;
        end
        BK_DIV: begin
          rem  <= rem_ge ? 32'(rem_sh - {1'b0, div_d}) : rem_sh[31:0];
          quo  <= {quo[23:0], rem_ge};
          num  <= {num[23:0], 1'b0};
          step <= step + 1'b1;
        end
        BK_DEC: begin
          out_ch.valid        <= 1'b1;
          out_ch.kind         <= 1'b1;
          out_ch.sample       <= '0;
          out_ch.beep_on      <= f_ok;
          out_ch.tone_restart <= f_ok && (fdiff > TONE_STEP_HZ);
          if (!f_ok) begin
            last_freq        <= '0;
            out_ch.tone_freq <= '0;
          end else if (fdiff > TONE_STEP_HZ) begin
            last_freq        <= quo[16:0];
            out_ch.tone_freq <= quo[16:0];
          end else begin
            out_ch.tone_freq <= last_freq;
          end
        end
        default: begin
        end
      endcase
    end
  end
endmodule

// ===== hw/rtl/buzzer_pin_audio_sampler_top.sv =====
// top level of the buzzer pin audio sampler: config registers, front, queue, back
// depends on bpas_pkg, bpas_if, bpas_front, bpas_fifo, bpas_back
//
//   channel  dir  handshake    payload
//   in_ch    in   valid/ready  command, pin_level, pin_average
//   out_ch   out  valid/ready  kind, sample, beep_on, tone_restart, tone_freq
//   cfg_ch   in   valid/ready  index, data (always ready)
//
// front takes one item per cycle while the queue has room
// back: audio sample by three multiplies on one multiplier, accumulate and round,
// tone status by a 25-step restoring divider, other status straight from idle;
// one entry at a time; result register holds while out_ch stalls
// synchronous reset; no clearing pass
module buzzer_pin_audio_sampler_top #(
  parameter int COEF_FRAC_BITS = 14,
  parameter int QUEUE_DEPTH    = 4
) (
  input logic    clk,
  input logic    rst,
  bpas_in_if.sink     in_ch,
  bpas_out_if.source  out_ch,
  bpas_cfg_if.sink    cfg_ch
);
  import bpas_pkg::*;

  cfg_t   cfg;
  logic   q_full;
  logic   q_push;
  entry_t q_push_data;
  logic   q_pop;
  entry_t q_pop_data;
  logic   q_valid;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{mode: 2'd0, active_high: 1'b1, pin_connected: 1'b0, decimation: 16'd100,
               sample_rate: 17'd44100, amplitude: 15'd32767, frame_limit: 16'd8820};
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_MODE:        cfg.mode          <= cfg_ch.data[1:0];
        REG_ACTIVE_HIGH: cfg.active_high   <= cfg_ch.data[0];
        REG_PIN_CONN:    cfg.pin_connected <= cfg_ch.data[0];
        REG_DECIMATION:  cfg.decimation    <= cfg_ch.data[15:0];
        REG_SAMPLE_RATE: cfg.sample_rate   <= cfg_ch.data[16:0];
        REG_AMPLITUDE:   cfg.amplitude     <= cfg_ch.data[14:0];
        REG_FRAME_LIMIT: cfg.frame_limit   <= cfg_ch.data[15:0];
        default: begin
        end
      endcase
    end
  end

  bpas_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  bpas_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_valid)
  );

  bpas_back #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_data  (q_pop_data),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );
endmodule

// ===== hw/rtl/bpas_checker.sv =====
// port-level checks of the buzzer pin audio sampler, bound to the top level
// depends on buzzer_pin_audio_sampler_top_assert.svh
`include "buzzer_pin_audio_sampler_top_assert.svh"

module bpas_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              kind,
  input logic signed [15:0] sample,
  input logic              beep_on,
  input logic              tone_restart,
  input logic [16:0]       tone_freq
);
  `BPAS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample) && $stable(tone_freq), "stalled result changed")
  `BPAS_ASSERT_NOW(a_sample_clean, out_valid && !kind, !beep_on && !tone_restart && tone_freq == 17'd0, "sample result carries status")
  `BPAS_ASSERT_NOW(a_status_clean, out_valid && kind, sample == 16'sd0, "status result carries sample")
  `BPAS_ASSERT_NOW(a_restart_freq, out_valid && tone_restart, beep_on && tone_freq != 17'd0, "restart without tone")
  `BPAS_ASSERT_RAW(a_reset_idle, $past(rst), !out_valid, "result valid after reset")
endmodule

bind buzzer_pin_audio_sampler_top bpas_checker u_bpas_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .kind         (out_ch.kind),
  .sample       (out_ch.sample),
  .beep_on      (out_ch.beep_on),
  .tone_restart (out_ch.tone_restart),
  .tone_freq    (out_ch.tone_freq)
);

// ===== sim/tb_buzzer_pin_audio_sampler_top.sv =====
`timescale 1ns / 100ps
// testbench of buzzer_pin_audio_sampler_top: directed frames, then random frames per mode
// depends on bpas_pkg, bpas_if and the rtl of the block; a scoreboard class predicts results
module tb_buzzer_pin_audio_sampler_top;
  import bpas_pkg::*;

  localparam int    FRAC   = 14;
  localparam longint CF_NUM = (64'sd7837 * (64'sd1 <<< FRAC) + 64'sd5000) / 64'sd10000;
  localparam longint CF_P1  = (64'sd1196 * (64'sd1 <<< FRAC) + 64'sd500) / 64'sd1000;
  localparam longint CF_P2  = (64'sd2068 * (64'sd1 <<< FRAC) + 64'sd5000) / 64'sd10000;

  typedef struct {
    logic               kind;
    logic signed [15:0] sample;
    logic               beep;
    logic               restart;
    logic [16:0]        freq;
  } result_t;

  class bpas_scoreboard;
    logic [1:0]  mode;
    logic        active_high, pin_conn;
    logic [15:0] decimation, frame_limit;
    logic [16:0] sample_rate;
    logic [14:0] amplitude;
    logic [15:0] tick_cnt, frame_cnt;
    int          in_hist[3];
    int          out_hist[3];
    logic [23:0] edge_cnt;
    logic [31:0] period_avg;
    logic        last_lvl;
    logic [16:0] last_freq;
    result_t     expected_q[$];
    int          errors, shown;

    function new();
      mode = MODE_ACTIVE; active_high = 1'b1; pin_conn = 1'b0; decimation = 16'd100;
      sample_rate = 17'd44100; amplitude = 15'd32767; frame_limit = 16'd8820;
      tick_cnt = '0; frame_cnt = '0; edge_cnt = '0; period_avg = '0; last_lvl = 1'b0;
      last_freq = '0;
      in_hist = '{0, 0, 0};
      out_hist = '{0, 0, 0};
      errors = 0; shown = 0;
    endfunction

    function void write_cfg(reg_idx_t idx, logic [16:0] d);
      case (idx)
        REG_MODE:        mode = d[1:0];
        REG_ACTIVE_HIGH: active_high = d[0];
        REG_PIN_CONN:    pin_conn = d[0];
        REG_DECIMATION:  decimation = d[15:0];
        REG_SAMPLE_RATE: sample_rate = d;
        REG_AMPLITUDE:   amplitude = d[14:0];
        REG_FRAME_LIMIT: frame_limit = d[15:0];
        default: ;
      endcase
    endfunction

    function bit fires();
      if (tick_cnt >= decimation) begin
        tick_cnt = '0;
        return 1;
      end
      tick_cnt++;
      return 0;
    endfunction

    function void note_input(cmd_t c, logic lvl, logic [7:0] avg);
      result_t     r;
      bit          emit, fired;
      logic        drive;
      longint      acc, y, t, f, dlt;
      logic [32:0] s;
      r = '{default: 0};
      emit = 0;
      case (c)
        CMD_TICK: begin
          if (mode == MODE_PASSIVE) begin
            fired = fires();
            if (fired && pin_conn && frame_cnt < frame_limit) begin
              drive = active_high ? lvl : !lvl;
              in_hist[2] = in_hist[1];
              in_hist[1] = in_hist[0];
              in_hist[0] = drive ? int'(amplitude) : -int'(amplitude);
              out_hist[2] = out_hist[1];
              out_hist[1] = out_hist[0];
              acc = CF_NUM * (longint'(in_hist[1]) - longint'(in_hist[2])) * 128
                  + CF_P1 * longint'(out_hist[1]) - CF_P2 * longint'(out_hist[2]);
              y = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
              if (y > 64'sd2147483647) y = 64'sd2147483647;
              if (y < -64'sd2147483648) y = -64'sd2147483648;
              out_hist[0] = int'(y);
              t = (y >= 0) ? (y >>> 8) : -((-y) >>> 8);
              if (t > 32767) t = 32767;
              if (t < -32768) t = -32768;
              frame_cnt++;
              r.sample = t[15:0];
              emit = 1;
            end
          end else if (mode == MODE_TONE) begin
            fired = fires();
            if (fired && pin_conn) begin
              if (!last_lvl && lvl) begin
                s = {1'b0, period_avg} + ({9'b0, edge_cnt} << 8);
                period_avg = s[32:1];
                edge_cnt = '0;
              end
              last_lvl = lvl;
              if (edge_cnt != EDGE_MAX) edge_cnt++;
            end
          end
        end
        CMD_START: begin
          if (mode == MODE_PASSIVE) tick_cnt = decimation;
          else if (mode == MODE_TONE) begin
            tick_cnt = decimation;
            edge_cnt = '0; last_lvl = 1'b0; period_avg = '0;
          end
        end
        CMD_END: begin
          emit = 1;
          r.kind = 1;
          if (mode == MODE_ACTIVE) begin
            if (pin_conn)
              r.beep = active_high ? (avg > ACT_HIGH_LIMIT)
                                   : ((ACT_LOW_BASE - avg) > ACT_LOW_LIMIT);
          end else if (mode == MODE_PASSIVE) begin
            frame_cnt = '0;
          end else if (mode == MODE_TONE) begin
            f = 0;
            if (period_avg > MIN_PERIOD_Q8)
              f = (longint'(sample_rate) << 8) / longint'(period_avg);
            if (f > MIN_TONE_HZ) begin
              dlt = (last_freq > f) ? longint'(last_freq) - f : f - longint'(last_freq);
              if (dlt > TONE_STEP_HZ) begin
                r.restart = 1;
                last_freq = f[16:0];
              end
              r.beep = 1;
            end else begin
              last_freq = '0;
            end
            r.freq = last_freq;
          end
        end
        default: ;
      endcase
      if (emit) expected_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (shown++ < 10) $display("unexpected result kind=%0d sample=%0d", got.kind, got.sample);
        return;
      end
      e = expected_q.pop_front();
      if (got.kind !== e.kind || got.sample !== e.sample || got.beep !== e.beep ||
          got.restart !== e.restart || got.freq !== e.freq) begin
        errors++;
        if (shown++ < 10)
          $display("mismatch exp kind=%0d sample=%0d beep=%0d restart=%0d freq=%0d, got %0d %0d %0d %0d %0d",
                   e.kind, e.sample, e.beep, e.restart, e.freq,
                   got.kind, got.sample, got.beep, got.restart, got.freq);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  always #1 clk = ~clk;

  bpas_in_if  in_ch();
  bpas_out_if out_ch();
  bpas_cfg_if cfg_ch();

  buzzer_pin_audio_sampler_top uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  bpas_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  bit hold = 0;
  int items_sent = 0;
  logic [7:0] act_avgs[4] = '{8'd0, 8'd65, 8'd66, 8'd255};

  initial begin
    in_ch.valid = 1'b0; in_ch.command = CMD_TICK; in_ch.pin_level = 1'b0;
    in_ch.pin_average = 8'd0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = REG_MODE; cfg_ch.data = 17'd0;
  end

  always @(posedge clk) begin
    out_ch.ready <= !hold && ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_cfg(reg_idx_t'(cfg_ch.index), cfg_ch.data);
      if (in_ch.valid && in_ch.ready)
        sb.note_input(cmd_t'(in_ch.command), in_ch.pin_level, in_ch.pin_average);
      if (out_ch.valid && out_ch.ready)
        sb.check_result('{out_ch.kind, out_ch.sample, out_ch.beep_on, out_ch.tone_restart,
                          out_ch.tone_freq});
    end
  end

  task automatic send_request(cmd_t c, logic l, logic [7:0] a);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= c;
    in_ch.pin_level <= l;
    in_ch.pin_average <= a;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [16:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_frame(int nticks);
    int half;
    logic l;
    half = $urandom_range(1, 40);
    send_request(CMD_START, 1'($urandom_range(1)), 8'($urandom_range(255)));
    for (int i = 0; i < nticks; i++) begin
      l = 1'((i / half) % 2);
      if ($urandom_range(19) == 0) l = !l;
      if ($urandom_range(29) == 0)
        send_request(cmd_t'($urandom_range(3)), 1'($urandom_range(1)),
                     8'($urandom_range(255)));
      else
        send_request(CMD_TICK, l, 8'($urandom_range(255)));
    end
    send_request(CMD_END, 1'($urandom_range(1)), 8'($urandom_range(255)));
  endtask

  task automatic random_config();
    logic [16:0] v;
    v = 17'($urandom_range(9));
    write_reg(REG_MODE, 17'((v < 4) ? MODE_PASSIVE : (v < 8) ? MODE_TONE : v[1:0] & 2'd3));
    write_reg(REG_ACTIVE_HIGH, 17'($urandom_range(1)));
    write_reg(REG_PIN_CONN, 17'($urandom_range(7) != 0));
    v = 17'($urandom_range(19));
    write_reg(REG_DECIMATION, (v == 0) ? 17'd65535 : 17'($urandom_range(3)));
    v = 17'($urandom_range(9));
    write_reg(REG_SAMPLE_RATE, (v == 0) ? 17'd1 : (v == 1) ? 17'd96000 :
                               17'($urandom_range(1, 96000)));
    v = 17'($urandom_range(9));
    write_reg(REG_AMPLITUDE, (v == 0) ? 17'd0 : (v == 1) ? 17'd32767 :
                             17'($urandom_range(32767)));
    v = 17'($urandom_range(9));
    write_reg(REG_FRAME_LIMIT, (v == 0) ? 17'd0 : (v == 1) ? 17'd65535 :
                               17'($urandom_range(40)));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // active mode, pin not connected, then thresholds both polarities, then mode none
    send_request(CMD_END, 1'b0, 8'd0);
    send_request(CMD_END, 1'b1, 8'd255);
    wait_idle();
    write_reg(REG_PIN_CONN, 17'd1);
    write_reg(REG_UNUSED, 17'h1FFFF);
    foreach (act_avgs[i]) send_request(CMD_END, 1'b0, act_avgs[i]);
    wait_idle();
    write_reg(REG_ACTIVE_HIGH, 17'd0);
    send_request(CMD_END, 1'b1, 8'd94);
    send_request(CMD_END, 1'b1, 8'd95);
    wait_idle();
    write_reg(REG_MODE, 17'(MODE_NONE));
    send_request(CMD_TICK, 1'b1, 8'd255);
    send_request(CMD_START, 1'b1, 8'd0);
    send_request(CMD_END, 1'b0, 8'd0);
    send_request(CMD_NONE, 1'b1, 8'd170);
    wait_idle();
    // passive, limit reached within the frame, then one tone frame
    write_reg(REG_MODE, 17'(MODE_PASSIVE));
    write_reg(REG_DECIMATION, 17'd0);
    write_reg(REG_FRAME_LIMIT, 17'd2);
    write_reg(REG_AMPLITUDE, 17'd32767);
    run_frame(4);
    wait_idle();
    write_reg(REG_MODE, 17'(MODE_TONE));
    write_reg(REG_SAMPLE_RATE, 17'd96000);
    run_frame(8);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 24 : 59) : 0;
      recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 24 : 59) : 0;
      if (ph == 2) send_idle = 0;
      items_sent = 0;
      if (ph == 0) begin
        write_reg(REG_MODE, 17'(MODE_PASSIVE));
        write_reg(REG_PIN_CONN, 17'd1);
        write_reg(REG_DECIMATION, 17'd0);
        write_reg(REG_FRAME_LIMIT, 17'd65535);
        fork
          begin
            hold = 1;
            repeat (300) @(posedge clk);
            hold = 0;
          end
        join_none
        run_frame(30);
      end
      while (items_sent < 120) begin
        wait_idle();
        random_config();
        repeat ($urandom_range(1, 3)) run_frame($urandom_range(5, 30));
      end
      wait_idle();
    end

    if (sb.expected_q.size() != 0) sb.errors++;
    if (sb.errors == 0) $display("tb_buzzer_pin_audio_sampler_top: PASS");
    else $display("tb_buzzer_pin_audio_sampler_top: FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_buzzer_pin_audio_sampler_top: FAIL");
    $finish;
  end

endmodule
